// ===== src/dmx_channel_crossfade_defines.svh =====
// assertion macros for the crossfade block
`ifndef DMX_CHANNEL_CROSSFADE_DEFINES_SVH
`define DMX_CHANNEL_CROSSFADE_DEFINES_SVH

// checked outside reset
`define DMXCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define DMXCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dmxcf_pkg.sv =====
package dmxcf_pkg;

  localparam int CHANNELS_DEF  = 512;
  localparam int TIME_BITS_DEF = 32;

  localparam int OP_W    = 2;
  localparam int CH_W    = 9;
  localparam int TIME_W  = 32;
  localparam int FADE_W  = 24;
  localparam int LEVEL_W = 8;
  localparam int LAT_W   = 9;

  localparam logic [LAT_W-1:0] LATENCY_MAX = LAT_W'(500);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_ARM     = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

endpackage

// ===== src/dmx_channel_crossfade.sv =====
// Per-channel linear crossfade engine for one lighting universe. Each transaction on the item
// channel is a load, an arm, an advance or a no-op on one channel, and yields exactly one result
// transaction with the channel, its level and whether a fade is still pending. Load, arm, no-op
// and out-of-range items go from S_READ straight to S_DONE. An advance does the same when no fade
// is pending or the fade is zero-length, ends after S_ELAPSED when the head is at or before the
// start or after S_CHECK when it is at or past the end, and else interpolates: one shared adder
// handles the head, elapsed and end checks, one 24x9 multiplier forms both products in S_MUL1 and
// S_MUL2, and the same adder then runs an 8-step restoring division for the rounded level. The
// block stalls items while one is in progress, and also while a finished result waits in the
// output register when the next result is ready. After reset a clearing pass over all CHANNELS
// entries zeroes all levels and fade flags before the first item is accepted; the latency register
// (saturated to 500 ms) can be written at any time.
`include "dmx_channel_crossfade_defines.svh"

module dmx_channel_crossfade
  import dmxcf_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LAT_W-1:0]   latency_ms,

  input  logic               item_valid,
  output logic               item_stall,
  input  logic [OP_W-1:0]    operation,
  input  logic [CH_W-1:0]    channel,
  input  logic [TIME_W-1:0]  time_ms,
  input  logic [FADE_W-1:0]  fade_ms,
  input  logic [LEVEL_W-1:0] level_in,

  output logic               result_valid,
  input  logic               result_stall,
  output logic [CH_W-1:0]    channel_out,
  output logic [LEVEL_W-1:0] level_out,
  output logic               fading
);

  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TW_EXT    = (TIME_BITS > TIME_W) ? TIME_BITS : TIME_W;
  localparam int NUM_W     = FADE_W + LEVEL_W + 2;
  localparam int ALU_W     = (TIME_BITS + 2 > NUM_W + 1) ? TIME_BITS + 2 : NUM_W + 1;
  localparam int PROD_W    = FADE_W + LEVEL_W + 1;
  localparam int ST_W      = LEVEL_W + 1;
  localparam int FD_W      = TIME_BITS + FADE_W + 2 * LEVEL_W;
  localparam int DIV_STEPS = LEVEL_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [CH_W:0]  CH_LIMIT = (CH_W + 1)'(CHANNELS);
  localparam logic [CH_AW-1:0] CH_LAST = CH_AW'(CHANNELS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [9:0] {
    S_CLEAR   = 10'b0000000001,
    S_IDLE    = 10'b0000000010,
    S_READ    = 10'b0000000100,
    S_ELAPSED = 10'b0000001000,
    S_CHECK   = 10'b0000010000,
    S_MUL1    = 10'b0000100000,
    S_MUL2    = 10'b0001000000,
    S_ACC     = 10'b0010000000,
    S_DIV     = 10'b0100000000,
    S_DONE    = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [CH_AW-1:0]   clr_idx;
  logic [LAT_W-1:0]   latency;

  op_t                op_r;
  logic [CH_W-1:0]    ch_r;
  logic [TIME_BITS-1:0] t_r;
  logic [FADE_W-1:0]  fade_in_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic               in_range;

  logic [TIME_BITS-1:0] f_start;
  logic [FADE_W-1:0]  f_fade;
  logic [LEVEL_W-1:0] f_from;
  logic [LEVEL_W-1:0] f_to;

  logic [LEVEL_W-1:0] res_level;
  logic               res_active;
  logic               wr_state;
  logic               wr_fade;

  logic [ALU_W-1:0]   acc;
  logic [ALU_W-1:0]   dvs;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   div_cnt;

  logic [TW_EXT-1:0]  time_ext;
  logic [TIME_BITS-1:0] t_in;
  logic               accept;
  logic               out_free;

  logic               st_we;
  logic [CH_AW-1:0]   st_waddr;
  logic [ST_W-1:0]    st_wdata;
  logic [ST_W-1:0]    st_rdata;
  logic               fd_we;
  logic [FD_W-1:0]    fd_wdata;
  logic [FD_W-1:0]    fd_rdata;

  logic [LEVEL_W-1:0] cur_level;
  logic               cur_active;
  logic [TIME_BITS-1:0] rd_start;
  logic [FADE_W-1:0]  rd_fade;
  logic [LEVEL_W-1:0] rd_from;
  logic [LEVEL_W-1:0] rd_to;

  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  logic               alu_sub;
  logic [ALU_W-1:0]   alu_sum;
  logic               alu_neg;
  logic               alu_zero;

  logic [FADE_W-1:0]  mul_a;
  logic [LEVEL_W:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic [LEVEL_W-1:0] abs_diff;

  logic [LEVEL_W-1:0] span_lo;
  logic [LEVEL_W-1:0] span_hi;
  logic               span_ok;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  assign time_ext = TW_EXT'(time_ms);
  assign t_in     = time_ext[TIME_BITS-1:0];

  assign cur_level  = st_rdata[LEVEL_W-1:0];
  assign cur_active = st_rdata[LEVEL_W];
  assign {rd_start, rd_fade, rd_from, rd_to} = fd_rdata;

  // shared adder
  always_comb begin
    alu_a   = acc;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      S_READ: begin
        alu_a = ALU_W'(t_r);
        alu_b = ALU_W'(latency);
      end
      S_ELAPSED: begin
        alu_b   = ALU_W'(f_start);
        alu_sub = 1'b1;
      end
      S_CHECK: begin
        alu_b   = ALU_W'(f_fade);
        alu_sub = 1'b1;
      end
      S_ACC: begin
        alu_b   = ALU_W'({prod, 1'b0});
        alu_sub = (f_to < f_from);
      end
      S_DIV: begin
        alu_b   = dvs;
        alu_sub = 1'b1;
      end
      default: begin
        alu_b = '0;
      end
    endcase
  end

  assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
  assign alu_neg  = alu_sum[ALU_W-1];
  assign alu_zero = (alu_sum == '0);

  // shared multiplier
  assign abs_diff = (f_to >= f_from) ? (f_to - f_from) : (f_from - f_to);
  assign mul_a    = (state == S_MUL1) ? f_fade : acc[FADE_W-1:0];
  assign mul_b    = (state == S_MUL1) ? {f_from, 1'b1} : {1'b0, abs_diff};
  assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == CH_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_DONE;
        if (in_range && op_r == OP_ADVANCE && cur_active && rd_fade != '0) begin
          state_next = S_ELAPSED;
        end
      end
      S_ELAPSED: begin
        state_next = (alu_neg || alu_zero) ? S_DONE : S_CHECK;
      end
      S_CHECK: begin
        state_next = alu_neg ? S_MUL1 : S_DONE;
      end
      S_MUL1: begin
        state_next = S_MUL2;
      end
      S_MUL2: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      latency      <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + CH_AW'(1);
      end
      if (cfg_valid && cfg_ready) begin
        latency <= (latency_ms > LATENCY_MAX) ? LATENCY_MAX : latency_ms;
      end
      if (state == S_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= op_t'(operation);
      ch_r      <= channel;
      t_r       <= t_in;
      fade_in_r <= fade_ms;
      lvl_r     <= level_in;
      in_range  <= ({1'b0, channel} < CH_LIMIT);
    end
    case (state)
      S_READ: begin
        acc        <= alu_sum;
        f_start    <= rd_start;
        f_fade     <= rd_fade;
        f_from     <= rd_from;
        f_to       <= rd_to;
        if (!in_range) begin
          res_level  <= '0;
          res_active <= 1'b0;
          wr_state   <= 1'b0;
          wr_fade    <= 1'b0;
        end else begin
          case (op_r)
            OP_LOAD: begin
              res_level  <= lvl_r;
              res_active <= cur_active;
              wr_state   <= 1'b1;
              wr_fade    <= 1'b0;
            end
            OP_ARM: begin
              res_level  <= cur_level;
              res_active <= 1'b1;
              wr_state   <= 1'b1;
              wr_fade    <= 1'b1;
            end
            OP_ADVANCE: begin
              wr_state <= cur_active;
              wr_fade  <= 1'b0;
              if (cur_active && rd_fade == '0) begin
                res_level  <= rd_to;
                res_active <= 1'b0;
              end else begin
                res_level  <= cur_level;
                res_active <= cur_active;
              end
            end
            default: begin
              res_level  <= cur_level;
              res_active <= cur_active;
              wr_state   <= 1'b0;
              wr_fade    <= 1'b0;
            end
          endcase
        end
      end
      S_ELAPSED: begin
        acc <= alu_sum;
      end
      S_CHECK: begin
        if (!alu_neg) begin
          res_level  <= f_to;
          res_active <= 1'b0;
        end
      end
      S_MUL1: begin
        prod <= mul_p;
      end
      S_MUL2: begin
        prod <= mul_p;
        acc  <= ALU_W'(prod);
      end
      S_ACC: begin
        acc     <= alu_sum;
        dvs     <= ALU_W'({f_fade, 1'b0}) << (DIV_STEPS - 1);
        div_cnt <= CNT_LAST;
      end
      S_DIV: begin
        if (!alu_neg) begin
          acc <= alu_sum;
        end
        dvs       <= dvs >> 1;
        div_cnt   <= div_cnt - CNT_W'(1);
        res_level <= {res_level[LEVEL_W-2:0], !alu_neg};
      end
      S_DONE: begin
        if (out_free) begin
          channel_out <= ch_r;
          level_out   <= res_level;
          fading      <= res_active;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // level/flag store, swept to zero after reset
  assign st_we    = (state == S_CLEAR) || (state == S_DONE && out_free && wr_state);
  assign st_waddr = (state == S_CLEAR) ? clr_idx : ch_r[CH_AW-1:0];
  assign st_wdata = (state == S_CLEAR) ? '0 : {res_active, res_level};

  assign fd_we    = (state == S_DONE) && out_free && wr_fade;
  assign fd_wdata = {t_r, fade_in_r, res_level, lvl_r};

  dmxcf_ram #(
    .WIDTH (ST_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (channel[CH_AW-1:0]),
    .rdata (st_rdata)
  );

  dmxcf_ram #(
    .WIDTH (FD_W),
    .DEPTH (CHANNELS)
  ) u_fade_ram (
    .clk   (clk),
    .we    (fd_we),
    .waddr (ch_r[CH_AW-1:0]),
    .wdata (fd_wdata),
    .raddr (channel[CH_AW-1:0]),
    .rdata (fd_rdata)
  );

  assign span_lo = (f_from < f_to) ? f_from : f_to;
  assign span_hi = (f_from < f_to) ? f_to : f_from;
  assign span_ok = (res_level >= span_lo) && (res_level <= span_hi);

  `DMXCF_ASSERT_ALWAYS(a_clear_after_reset, $fell(rst) |-> state == S_CLEAR, "no clear pass")
  `DMXCF_ASSERT(a_div_in_span, (state == S_DIV && div_cnt == '0) |=> span_ok, "level out of span")
  `DMXCF_ASSERT(a_state_write, st_we |-> (state == S_CLEAR || state == S_DONE), "stray write")
  `DMXCF_ASSERT(a_fade_write, fd_we |-> (op_r == OP_ARM && in_range), "fade write without arm")
  `DMXCF_ASSERT(a_latency_max, latency <= LATENCY_MAX, "latency above saturation limit")

endmodule

// ===== src/dmxcf_ram.sv =====
module dmxcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
